>>> sv/adsr_pkg.sv
// Shared types, constants and helpers for the ADSR envelope shaper.
package adsr_pkg;

   localparam int SAMPLE_BITS        = 16;
   localparam int COUNT_BITS_DEFAULT = 24;
   localparam int LEVEL_BITS         = 16;
   localparam int ENV_SHIFT          = 8;
   localparam int ENV_BITS           = LEVEL_BITS + ENV_SHIFT;
   localparam int ENV_FRAC           = 23;
   localparam int LEVEL_W            = ENV_BITS + 1;
   localparam int QUEUE_DEPTH        = 2;
   localparam int CSR_ADDR_BITS      = 3;

   localparam logic [LEVEL_BITS-1:0] LEVEL_ONE           = 16'd32768;
   localparam logic [LEVEL_BITS-1:0] ATTACK_LEVEL_RESET  = 16'd32768;
   localparam logic [LEVEL_BITS-1:0] SUSTAIN_LEVEL_RESET = 16'd16384;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_ATTACK_COUNT  = 3'd0,
      CSR_DECAY_COUNT   = 3'd1,
      CSR_SUSTAIN_COUNT = 3'd2,
      CSR_RELEASE_COUNT = 3'd3,
      CSR_ATTACK_LEVEL  = 3'd4,
      CSR_SUSTAIN_LEVEL = 3'd5
   } csr_reg_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          last_sample;
   } req_beat_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          last_out;
   } rsp_beat_type;

   typedef struct packed {
      logic                start;
      logic [ENV_BITS-1:0] dividend;
   } div_cmd_type;

   // Q1.15 level clamped to 1.0 and widened to Q1.23
   function automatic logic [ENV_BITS-1:0] level_q23(input logic [LEVEL_BITS-1:0] lv);
      logic [LEVEL_BITS-1:0] c;
      c = (lv > LEVEL_ONE) ? LEVEL_ONE : lv;
      return {c, {ENV_SHIFT{1'b0}}};
   endfunction

endpackage

>>> sv/adsr_req_queue.sv
// Input beat queue between the request port and the envelope engine.
module adsr_req_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  adsr_pkg::req_beat_type push_data,
   output logic                  head_valid,
   output adsr_pkg::req_beat_type head_data,
   input  logic                  head_pop
);
   import adsr_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   req_beat_type         mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [CNT_W-1:0]     count_ff;
   logic                 do_push;
   logic                 do_pop;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = head_pop && head_valid;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

>>> sv/adsr_divider.sv
// Bit-serial restoring divider for per-phase envelope steps.
module adsr_divider #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  adsr_pkg::div_cmd_type         cmd,
   input  logic [COUNT_BITS-1:0]         divisor,
   output logic                          done,
   output logic [adsr_pkg::ENV_BITS-1:0] quotient
);
   import adsr_pkg::*;

   localparam int CNT_W = $clog2(ENV_BITS + 1);

   logic [COUNT_BITS-1:0] rem_ff;
   logic [ENV_BITS-1:0]   quo_ff;
   logic [COUNT_BITS-1:0] den_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS:0]   diff;
   logic                  ge;

   assign shifted  = {rem_ff, quo_ff[ENV_BITS-1]};
   assign diff     = shifted - {1'b0, den_ff};
   assign ge       = (shifted >= {1'b0, den_ff});
   assign done     = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            rem_ff  <= '0;
            quo_ff  <= cmd.dividend;
            den_ff  <= divisor;
            cnt_ff  <= CNT_W'(ENV_BITS);
         end else if (busy_ff) begin
            rem_ff <= ge ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
            quo_ff <= {quo_ff[ENV_BITS-2:0], ge};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

endmodule

>>> sv/adsr_engine.sv
// Envelope sequencer: phase starts, envelope update, multiply, round and saturate.
module adsr_engine #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  adsr_pkg::req_beat_type          req_beat,
   output logic                            req_pop,
   output logic                            rsp_valid,
   output adsr_pkg::rsp_beat_type          rsp_beat,
   input  logic                            rsp_pop,
   input  logic [COUNT_BITS-1:0]           attack_count,
   input  logic [COUNT_BITS-1:0]           decay_count,
   input  logic [COUNT_BITS-1:0]           sustain_count,
   input  logic [COUNT_BITS-1:0]           release_count,
   input  logic [adsr_pkg::LEVEL_BITS-1:0] attack_level,
   input  logic [adsr_pkg::LEVEL_BITS-1:0] sustain_level
);
   import adsr_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + LEVEL_W;
   localparam int Q_W    = PROD_W + 1 - ENV_FRAC;
   localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (ENV_FRAC - 1);
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   typedef enum logic [2:0] {
      PH_ATTACK, PH_DECAY, PH_SUSTAIN, PH_RELEASE, PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      ST_CHECK, ST_DIV, ST_OUT
   } state_type;

   state_type                   state_ff;
   phase_type                   phase_ff;
   logic                        note_start_ff;
   logic [COUNT_BITS-1:0]       remaining_ff;
   logic signed [LEVEL_W-1:0]   level_ff;
   logic signed [LEVEL_W-1:0]   step_ff;
   logic                        step_neg_ff;
   logic signed [PROD_W-1:0]    prod_ff;
   logic                        last_ff;
   logic                        rsp_valid_ff;
   rsp_beat_type                rsp_beat_ff;

   logic [ENV_BITS-1:0]         a_q23;
   logic [ENV_BITS-1:0]         s_q23;
   logic                        need_start;
   phase_type                   next_ph;
   phase_type                   start_ph;
   logic [COUNT_BITS-1:0]       start_cnt;
   logic signed [LEVEL_W-1:0]   start_level;
   logic                        start_ramp;
   logic                        start_neg;
   logic                        div_start;
   logic [ENV_BITS-1:0]         div_dividend;
   div_cmd_type                 div_cmd;
   logic                        div_done;
   logic [ENV_BITS-1:0]         div_quo;
   logic signed [LEVEL_W-1:0]   quo_s;
   logic signed [LEVEL_W-1:0]   env;
   logic signed [LEVEL_W-1:0]   level_in;
   logic signed [PROD_W-1:0]    prod_in;
   logic [PROD_W:0]             rounded;
   logic [Q_W-1:0]              q_val;
   logic [Q_W-SAMPLE_BITS:0]    q_high;
   logic [SAMPLE_BITS-1:0]      sat_val;

   assign a_q23      = level_q23(attack_level);
   assign s_q23      = level_q23(sustain_level);
   assign need_start = note_start_ff || (phase_ff != PH_DONE && remaining_ff == '0);
   assign start_ph   = note_start_ff ? PH_ATTACK : next_ph;

   always_comb begin
      unique case (phase_ff)
         PH_ATTACK:  next_ph = PH_DECAY;
         PH_DECAY:   next_ph = PH_SUSTAIN;
         PH_SUSTAIN: next_ph = PH_RELEASE;
         default:    next_ph = PH_DONE;
      endcase
   end

   always_comb begin
      start_cnt    = '0;
      start_level  = '0;
      start_ramp   = 1'b0;
      start_neg    = 1'b0;
      div_dividend = '0;
      unique case (start_ph)
         PH_ATTACK: begin
            start_cnt    = attack_count;
            start_ramp   = 1'b1;
            div_dividend = a_q23;
         end
         PH_DECAY: begin
            start_cnt    = decay_count;
            start_level  = $signed({1'b0, a_q23});
            start_ramp   = 1'b1;
            start_neg    = (s_q23 > a_q23);
            div_dividend = start_neg ? (s_q23 - a_q23) : (a_q23 - s_q23);
         end
         PH_SUSTAIN: begin
            start_cnt   = sustain_count;
            start_level = $signed({1'b0, s_q23});
         end
         PH_RELEASE: begin
            start_cnt    = release_count;
            start_level  = $signed({1'b0, s_q23});
            start_ramp   = 1'b1;
            div_dividend = s_q23;
         end
         default: begin
            start_cnt = '0;
         end
      endcase
   end

   assign div_start = (state_ff == ST_CHECK) && req_valid && need_start &&
                      start_ramp && (start_cnt != '0);
   assign div_cmd   = {div_start, div_dividend};

   adsr_divider #(
      .COUNT_BITS (COUNT_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .divisor  (start_cnt),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign quo_s = $signed({1'b0, div_quo});

   always_comb begin
      unique case (phase_ff)
         PH_ATTACK: begin
            env      = level_ff;
            level_in = level_ff + step_ff;
         end
         PH_DECAY: begin
            env      = level_ff;
            level_in = level_ff - step_ff;
         end
         PH_SUSTAIN: begin
            env      = level_ff;
            level_in = level_ff;
         end
         PH_RELEASE: begin
            env      = level_ff - step_ff;
            level_in = level_ff - step_ff;
         end
         default: begin
            env      = '0;
            level_in = level_ff;
         end
      endcase
   end

   assign prod_in = req_beat.sample_in * env;

   // round half up in Q1.23, then clip to the sample range
   assign rounded = {prod_ff[PROD_W-1], prod_ff} + ROUND_HALF;
   assign q_val   = rounded[PROD_W:ENV_FRAC];
   assign q_high  = q_val[Q_W-1:SAMPLE_BITS-1];
   assign sat_val = (&q_high || ~|q_high) ? q_val[SAMPLE_BITS-1:0] :
                    (q_val[Q_W-1] ? SAMPLE_MIN : SAMPLE_MAX);

   assign req_pop   = (state_ff == ST_CHECK) && req_valid && !need_start;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CHECK;
         phase_ff      <= PH_ATTACK;
         note_start_ff <= 1'b1;
         remaining_ff  <= '0;
         level_ff      <= '0;
         step_ff       <= '0;
         step_neg_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_pop && rsp_valid_ff && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CHECK: begin
               if (req_valid) begin
                  if (need_start) begin
                     note_start_ff <= 1'b0;
                     phase_ff      <= start_ph;
                     remaining_ff  <= start_cnt;
                     level_ff      <= start_level;
                     step_ff       <= '0;
                     step_neg_ff   <= start_neg;
                     if (div_start) begin
                        state_ff <= ST_DIV;
                     end
                  end else begin
                     prod_ff <= prod_in;
                     last_ff <= req_beat.last_sample;
                     if (req_beat.last_sample) begin
                        note_start_ff <= 1'b1;
                        phase_ff      <= PH_ATTACK;
                        remaining_ff  <= '0;
                        level_ff      <= '0;
                        step_ff       <= '0;
                     end else begin
                        level_ff <= level_in;
                        if (phase_ff != PH_DONE) begin
                           remaining_ff <= remaining_ff - 1'b1;
                        end
                     end
                     state_ff <= ST_OUT;
                  end
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  step_ff  <= step_neg_ff ? -quo_s : quo_s;
                  state_ff <= ST_CHECK;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_pop) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_beat_ff.sample_out <= $signed(sat_val);
                  rsp_beat_ff.last_out   <= last_ff;
                  state_ff               <= ST_CHECK;
               end
            end
            default: begin
               state_ff <= ST_CHECK;
            end
         endcase
      end
   end

endmodule

>>> sv/adsr_envelope_shaper.sv
// Top level of the ADSR envelope shaper: register file, input queue and engine.
//
// Each request beat carries one signed sample; the block returns that sample
// scaled by a linear attack/decay/sustain/release envelope (Q1.23), rounded and
// saturated. Within a phase each sample gets an envelope update and multiply,
// then round and hand-off to the response register, which waits while the last
// result is still unread. Each phase start first takes a setup step; attack,
// decay and release with a nonzero count also run the bit-serial step divider.
// A beat marked last closes the note and the next beat starts a fresh attack.
// Phase counts and levels are read as each phase starts, so write them while idle.
module adsr_envelope_shaper #(
   parameter int COUNT_BITS = adsr_pkg::COUNT_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  adsr_pkg::req_beat_type                 req_data,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output adsr_pkg::rsp_beat_type                 rsp_data,
   input  logic                                   csr_we,
   input  logic [adsr_pkg::CSR_ADDR_BITS-1:0]     csr_addr,
   input  logic [((COUNT_BITS > adsr_pkg::LEVEL_BITS) ?
                  COUNT_BITS : adsr_pkg::LEVEL_BITS)-1:0] csr_wdata
);
   import adsr_pkg::*;

   logic [COUNT_BITS-1:0] attack_count_ff;
   logic [COUNT_BITS-1:0] decay_count_ff;
   logic [COUNT_BITS-1:0] sustain_count_ff;
   logic [COUNT_BITS-1:0] release_count_ff;
   logic [LEVEL_BITS-1:0] attack_level_ff;
   logic [LEVEL_BITS-1:0] sustain_level_ff;

   logic                  head_valid;
   req_beat_type          head_data;
   logic                  head_pop;
   logic                  rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_count_ff  <= '0;
         decay_count_ff   <= '0;
         sustain_count_ff <= '0;
         release_count_ff <= '0;
         attack_level_ff  <= ATTACK_LEVEL_RESET;
         sustain_level_ff <= SUSTAIN_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ATTACK_COUNT:  attack_count_ff  <= csr_wdata[COUNT_BITS-1:0];
            CSR_DECAY_COUNT:   decay_count_ff   <= csr_wdata[COUNT_BITS-1:0];
            CSR_SUSTAIN_COUNT: sustain_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_RELEASE_COUNT: release_count_ff <= csr_wdata[COUNT_BITS-1:0];
            CSR_ATTACK_LEVEL:  attack_level_ff  <= csr_wdata[LEVEL_BITS-1:0];
            CSR_SUSTAIN_LEVEL: sustain_level_ff <= csr_wdata[LEVEL_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   adsr_req_queue u_req_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .full       (req_full),
      .push_data  (req_data),
      .head_valid (head_valid),
      .head_data  (head_data),
      .head_pop   (head_pop)
   );

   adsr_engine #(
      .COUNT_BITS (COUNT_BITS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (head_valid),
      .req_beat      (head_data),
      .req_pop       (head_pop),
      .rsp_valid     (rsp_valid),
      .rsp_beat      (rsp_data),
      .rsp_pop       (rsp_pop),
      .attack_count  (attack_count_ff),
      .decay_count   (decay_count_ff),
      .sustain_count (sustain_count_ff),
      .release_count (release_count_ff),
      .attack_level  (attack_level_ff),
      .sustain_level (sustain_level_ff)
   );

   assign rsp_empty = !rsp_valid;

endmodule

>>> tb/sv/adsr_envelope_shaper_tb.sv
// Testbench for the ADSR envelope shaper: a directed table, then random notes checked by a predictor.
`timescale 1ns / 1ps

module adsr_envelope_shaper_tb;
   import adsr_pkg::*;

   localparam int COUNT_W         = COUNT_BITS_DEFAULT;
   localparam int CSR_W           = (COUNT_W > LEVEL_BITS) ? COUNT_W : LEVEL_BITS;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNUSED_LO = 3'd6;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_UNUSED_HI = 3'd7;
   localparam int NUM_DIRECTED    = 41;
   localparam int NUM_PHASES      = 12;
   localparam int BEATS_PER_PHASE = 100;
   localparam int SPAN_CAP        = 60;
   localparam int SETTLE_CYCLES   = 120;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int END_CYCLES      = 200;
   localparam int WATCHDOG_LIMIT  = 4000;

   typedef enum logic [2:0] {
      ENV_ATTACK, ENV_DECAY, ENV_SUSTAIN, ENV_RELEASE, ENV_DONE
   } env_phase_type;

   typedef enum logic {ROW_CSR, ROW_BEAT} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [CSR_ADDR_BITS-1:0]      addr;
      logic [CSR_W-1:0]              wdata;
      req_beat_type                  beat;
      logic                          known;
      logic signed [SAMPLE_BITS-1:0] known_out;
   } directed_row_type;

   typedef struct packed {
      rsp_beat_type                  beat;
      logic                          known;
      logic signed [SAMPLE_BITS-1:0] known_out;
   } shaped_beat_type;

   logic                     clock     = 1'b0;
   logic                     reset     = 1'b1;
   logic                     req_push  = 1'b0;
   logic                     req_full;
   req_beat_type             req_data  = '0;
   logic                     rsp_empty;
   logic                     rsp_pop   = 1'b0;
   rsp_beat_type             rsp_data;
   logic                     csr_we    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr  = '0;
   logic [CSR_W-1:0]         csr_wdata = '0;

   // envelope predictor state
   logic [COUNT_W-1:0]    cfg_attack_count, cfg_decay_count, cfg_sustain_count, cfg_release_count;
   logic [LEVEL_BITS-1:0] cfg_attack_level, cfg_sustain_level;
   env_phase_type         env_phase;
   logic [COUNT_W-1:0]    env_left;
   int                    env_level, env_step;
   bit                    env_restart;

   shaped_beat_type               shaped_q [$];
   logic signed [SAMPLE_BITS-1:0] table_out [int];
   directed_row_type              directed_rows [NUM_DIRECTED];
   int                            sent_count  = 0;
   int                            item_seq    = 0;
   int                            failures    = 0;
   int                            idle_cycles = 0;
   bit                            hold_off_req = 1'b0;

   adsr_envelope_shaper #(
      .COUNT_BITS(COUNT_W)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int env_of_level(logic [LEVEL_BITS-1:0] lv);
      return ((lv > LEVEL_ONE) ? 32768 : int'(lv)) * 256;
   endfunction

   function automatic void begin_phase(env_phase_type ph);
      int a, s;
      a = env_of_level(cfg_attack_level);
      s = env_of_level(cfg_sustain_level);
      env_phase = ph;
      case (ph)
         ENV_ATTACK: begin
            env_left  = cfg_attack_count;
            env_level = 0;
            env_step  = (cfg_attack_count != 0) ? a / int'(cfg_attack_count) : 0;
         end
         ENV_DECAY: begin
            env_left  = cfg_decay_count;
            env_level = a;
            env_step  = (cfg_decay_count != 0) ? (a - s) / int'(cfg_decay_count) : 0;
         end
         ENV_SUSTAIN: begin
            env_left  = cfg_sustain_count;
            env_level = s;
            env_step  = 0;
         end
         ENV_RELEASE: begin
            env_left  = cfg_release_count;
            env_level = s;
            env_step  = (cfg_release_count != 0) ? s / int'(cfg_release_count) : 0;
         end
         default: begin
            env_phase = ENV_DONE;
            env_left  = '0;
            env_level = 0;
            env_step  = 0;
         end
      endcase
   endfunction

   function automatic rsp_beat_type shape_sample(req_beat_type b);
      rsp_beat_type r;
      int           env;
      longint       prod, q;
      if (env_restart) begin
         env_restart = 1'b0;
         begin_phase(ENV_ATTACK);
      end
      while (env_phase != ENV_DONE && env_left == 0)
         begin_phase(env_phase_type'(env_phase + 3'd1));
      case (env_phase)
         ENV_ATTACK: begin
            env = env_level;
            env_level += env_step;
         end
         ENV_DECAY: begin
            env = env_level;
            env_level -= env_step;
         end
         ENV_SUSTAIN: env = env_level;
         ENV_RELEASE: begin
            env_level -= env_step;
            env = env_level;
         end
         default: env = 0;
      endcase
      if (env_phase != ENV_DONE) env_left--;
      prod = longint'($signed(b.sample_in)) * longint'(env) + 64'sd4194304;
      q = prod >>> ENV_FRAC;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      r.sample_out = q[SAMPLE_BITS-1:0];
      r.last_out   = b.last_sample;
      if (b.last_sample) begin
         env_restart = 1'b1;
         env_phase   = ENV_ATTACK;
         env_left    = '0;
         env_level   = 0;
         env_step    = 0;
      end
      return r;
   endfunction

   // register writes and accepted input beats feed the predictor
   always @(posedge clock) begin : predict
      shaped_beat_type e;
      if (reset) begin
         cfg_attack_count  = '0;
         cfg_decay_count   = '0;
         cfg_sustain_count = '0;
         cfg_release_count = '0;
         cfg_attack_level  = ATTACK_LEVEL_RESET;
         cfg_sustain_level = SUSTAIN_LEVEL_RESET;
         env_phase         = ENV_ATTACK;
         env_left          = '0;
         env_level         = 0;
         env_step          = 0;
         env_restart       = 1'b1;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_ATTACK_COUNT:  cfg_attack_count  = csr_wdata[COUNT_W-1:0];
               CSR_DECAY_COUNT:   cfg_decay_count   = csr_wdata[COUNT_W-1:0];
               CSR_SUSTAIN_COUNT: cfg_sustain_count = csr_wdata[COUNT_W-1:0];
               CSR_RELEASE_COUNT: cfg_release_count = csr_wdata[COUNT_W-1:0];
               CSR_ATTACK_LEVEL:  cfg_attack_level  = csr_wdata[LEVEL_BITS-1:0];
               CSR_SUSTAIN_LEVEL: cfg_sustain_level = csr_wdata[LEVEL_BITS-1:0];
               default: ;
            endcase
         end
         if (req_push && !req_full) begin
            e.beat      = shape_sample(req_data);
            e.known     = table_out.exists(item_seq);
            e.known_out = e.known ? table_out[item_seq] : '0;
            shaped_q.push_back(e);
            item_seq++;
         end
      end
   end

   always @(posedge clock) begin : check_results
      shaped_beat_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (shaped_q.size() == 0) begin
            $error("result beat with nothing expected: sample_out=%0d last_out=%0b",
                   rsp_data.sample_out, rsp_data.last_out);
            failures++;
         end else begin
            e = shaped_q.pop_front();
            if (rsp_data.sample_out !== e.beat.sample_out) begin
               $error("sample_out: expected %0d, actual %0d",
                      e.beat.sample_out, rsp_data.sample_out);
               failures++;
            end
            if (rsp_data.last_out !== e.beat.last_out) begin
               $error("last_out: expected %0b, actual %0b", e.beat.last_out, rsp_data.last_out);
               failures++;
            end
            if (e.known && rsp_data.sample_out !== e.known_out) begin
               $error("sample_out (table): expected %0d, actual %0d",
                      e.known_out, rsp_data.sample_out);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // receiver: randomly chosen stall patterns, plus one long hold-off
   initial begin : receiver
      int mode, left;
      mode = 0;
      left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_pop <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(20, 200);
         end
         left--;
         case (mode)
            0: rsp_pop <= 1'b1;
            1: rsp_pop <= ($urandom_range(0, 3) != 0);
            2: rsp_pop <= $urandom_range(0, 1);
            default: rsp_pop <= ($urandom_range(0, 7) == 0);
         endcase
         @(posedge clock);
      end
   end

   task automatic send_beat(req_beat_type b);
      req_push <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (req_full !== 1'b0);
      sent_count++;
   endtask

   task automatic write_csr(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_W-1:0] wdata);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= wdata;
      @(posedge clock);
   endtask

   task automatic settle_idle();
      req_push <= 1'b0;
      while (shaped_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 19))
         0, 1:    return '0;
         2, 3:    return COUNT_W'(1);
         4:       return '1;
         default: return COUNT_W'($urandom_range(2, 40));
      endcase
   endfunction

   function automatic logic [LEVEL_BITS-1:0] pick_level();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return LEVEL_ONE;
         2:       return LEVEL_BITS'($urandom_range(32769, 65535));
         default: return LEVEL_BITS'($urandom_range(0, 32768));
      endcase
   endfunction

   // phase 0: shortest ramps, phase 1: longest ramps and clamped levels
   task automatic program_envelope(input int ph, output int span);
      logic [COUNT_W-1:0]    cnt [4];
      logic [LEVEL_BITS-1:0] lv [2];
      logic [CSR_W-1:0]      wd;
      for (int k = 0; k < 4; k++)
         cnt[k] = (ph == 0) ? COUNT_W'(1) : (ph == 1) ? '1 : pick_count();
      lv[0] = (ph == 0) ? LEVEL_ONE : (ph == 1) ? '1 : pick_level();
      lv[1] = (ph == 0) ? '0 : (ph == 1) ? '1 : pick_level();
      settle_idle();
      write_csr(CSR_ATTACK_COUNT, cnt[0]);
      write_csr(CSR_DECAY_COUNT, cnt[1]);
      write_csr(CSR_SUSTAIN_COUNT, cnt[2]);
      write_csr(CSR_RELEASE_COUNT, cnt[3]);
      for (int k = 0; k < 2; k++) begin
         wd = CSR_W'($urandom());
         wd[LEVEL_BITS-1:0] = lv[k];
         write_csr(k == 0 ? CSR_ATTACK_LEVEL : CSR_SUSTAIN_LEVEL, wd);
      end
      if ($urandom_range(0, 1))
         write_csr($urandom_range(0, 1) ? CSR_UNUSED_LO : CSR_UNUSED_HI, CSR_W'($urandom()));
      csr_we <= 1'b0;
      span = 0;
      for (int k = 0; k < 4; k++)
         span += (cnt[k] > SPAN_CAP) ? SPAN_CAP : int'(cnt[k]);
   endtask

   function automatic directed_row_type csr_row(logic [CSR_ADDR_BITS-1:0] addr,
                                                logic [CSR_W-1:0] wdata);
      directed_row_type r;
      r       = '0;
      r.kind  = ROW_CSR;
      r.addr  = addr;
      r.wdata = wdata;
      return r;
   endfunction

   function automatic directed_row_type beat_row(logic signed [SAMPLE_BITS-1:0] s, logic l,
                                                 logic known = 1'b0,
                                                 logic signed [SAMPLE_BITS-1:0] out = '0);
      directed_row_type r;
      r                  = '0;
      r.kind             = ROW_BEAT;
      r.beat.sample_in   = s;
      r.beat.last_sample = l;
      r.known            = known;
      r.known_out        = out;
      return r;
   endfunction

   initial begin : stimulus
      req_beat_type b;
      int           span, note_left, burst_left, gap;
      bit           gaps_on, prev_csr;

      directed_rows = '{
         // all phase counts zero after reset: envelope is zero
         beat_row(16'sh7FFF, 1'b0, 1'b1, 16'sd0),
         beat_row(16'sh8000, 1'b1, 1'b1, 16'sd0),
         // sustain only at unity, then past release
         csr_row(CSR_SUSTAIN_COUNT, 24'd3),
         csr_row(CSR_SUSTAIN_LEVEL, 24'd32768),
         beat_row(16'sh7FFF, 1'b0, 1'b1, 16'sh7FFF),
         beat_row(16'sh8000, 1'b0, 1'b1, 16'sh8000),
         beat_row(16'sd1, 1'b0, 1'b1, 16'sd1),
         beat_row(16'sd1234, 1'b1, 1'b1, 16'sd0),
         // level above unity, upper data bits set
         csr_row(CSR_SUSTAIN_LEVEL, 24'hFFFFFF),
         beat_row(16'sh8000, 1'b1, 1'b1, 16'sh8000),
         // half level: rounding of odd and negative products
         csr_row(CSR_SUSTAIN_LEVEL, 24'd16384),
         beat_row(16'sh7FFF, 1'b0, 1'b1, 16'sd16384),
         beat_row(16'shFFFF, 1'b0, 1'b1, 16'sd0),
         beat_row(16'sh8000, 1'b1, 1'b1, 16'shC000),
         // full note, unused indexes ignored
         csr_row(CSR_ATTACK_COUNT, 24'd2),
         csr_row(CSR_DECAY_COUNT, 24'd2),
         csr_row(CSR_SUSTAIN_COUNT, 24'd1),
         csr_row(CSR_RELEASE_COUNT, 24'd2),
         csr_row(CSR_ATTACK_LEVEL, 24'd32768),
         csr_row(CSR_SUSTAIN_LEVEL, 24'd8192),
         csr_row(CSR_UNUSED_LO, 24'd5),
         csr_row(CSR_UNUSED_HI, 24'hFFFFFF),
         beat_row(16'sh7FFF, 1'b0, 1'b1, 16'sd0),
         beat_row(16'sh8000, 1'b0),
         beat_row(16'sh7FFF, 1'b0),
         beat_row(16'sh8000, 1'b0),
         beat_row(16'sh7FFF, 1'b0),
         beat_row(16'sh8000, 1'b0),
         beat_row(16'sh7FFF, 1'b0),
         beat_row(16'sh8000, 1'b1, 1'b1, 16'sd0),
         // sustain above attack: decay ramps up, sustain skipped
         csr_row(CSR_ATTACK_COUNT, 24'd1),
         csr_row(CSR_DECAY_COUNT, 24'd3),
         csr_row(CSR_SUSTAIN_COUNT, 24'd0),
         csr_row(CSR_RELEASE_COUNT, 24'd1),
         csr_row(CSR_ATTACK_LEVEL, 24'd4096),
         csr_row(CSR_SUSTAIN_LEVEL, 24'd32768),
         beat_row(16'sd20000, 1'b0, 1'b1, 16'sd0),
         beat_row(-16'sd20000, 1'b0),
         beat_row(16'sh7FFF, 1'b0),
         beat_row(16'sh8000, 1'b0),
         beat_row(16'sd12345, 1'b1, 1'b1, 16'sd0)
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      prev_csr = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (!prev_csr) settle_idle();
            write_csr(directed_rows[i].addr, directed_rows[i].wdata);
            prev_csr = 1'b1;
         end else begin
            if (prev_csr) csr_we <= 1'b0;
            prev_csr = 1'b0;
            if (directed_rows[i].known) table_out[sent_count] = directed_rows[i].known_out;
            send_beat(directed_rows[i].beat);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         program_envelope(ph, span);
         gaps_on    = ($urandom_range(0, 3) != 0);
         burst_left = 0;
         note_left  = 0;
         for (int i = 0; i < BEATS_PER_PHASE; i++) begin
            if (ph == 3 && i == 10) hold_off_req = 1'b1;
            if (ph == 6 && i == 50) settle_idle();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 30);
               if (gaps_on) begin
                  gap = $urandom_range(1, 15);
                  req_push <= 1'b0;
                  repeat (gap) @(posedge clock);
               end
            end
            burst_left--;
            // mostly whole notes; some short broken ones
            if (note_left == 0) begin
               if ($urandom_range(0, 4) != 0) note_left = $urandom_range(1, span + 6);
               else note_left = $urandom_range(1, 3);
            end
            note_left--;
            case ($urandom_range(0, 7))
               0:       b.sample_in = 16'sh7FFF;
               1:       b.sample_in = 16'sh8000;
               default: b.sample_in = SAMPLE_BITS'($urandom());
            endcase
            b.last_sample = (note_left == 0);
            send_beat(b);
         end
      end

      settle_idle();
      repeat (END_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
